FILE: rtl/sorted_key_record_table_core_macros.svh
// assertion helpers shared by the sorted key record table
`ifndef SORTED_KEY_RECORD_TABLE_CORE_MACROS_SVH
`define SORTED_KEY_RECORD_TABLE_CORE_MACROS_SVH

// check that is suspended while reset is high
`define SKRT_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds during reset
`define SKRT_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/skrt_pkg.sv
`timescale 1ns / 1ps

package skrt_pkg;

  // default table depth
  localparam int CAPACITY_DEF = 16;

  // operation codes
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_INSERT = 2'd0;
  localparam cmd_t CMD_DELETE = 2'd1;
  localparam cmd_t CMD_SEARCH = 2'd2;

  // result status codes
  typedef logic [2:0] status_t;
  localparam status_t ST_INSERTED  = 3'd0;
  localparam status_t ST_DUPLICATE = 3'd1;
  localparam status_t ST_FULL      = 3'd2;
  localparam status_t ST_DELETED   = 3'd3;
  localparam status_t ST_NOT_FOUND = 3'd4;
  localparam status_t ST_FOUND     = 3'd5;

  // request item
  typedef struct packed {
    cmd_t               cmd;
    logic signed [31:0] key;
    logic [63:0]        name_tag;
  } req_t;

  // response item
  typedef struct packed {
    status_t     status;
    logic [63:0] name_out;
    logic [3:0]  position;
    logic [4:0]  entry_count;
  } rsp_t;

  // control broadcast to every cell
  typedef struct packed {
    logic               cmp;
    logic               ins;
    logic               del;
    logic signed [31:0] cmp_key;
    logic signed [31:0] new_key;
    logic [63:0]        new_name;
  } ctl_t;

endpackage

FILE: rtl/sorted_key_record_table_core.sv
`timescale 1ns / 1ps
// Steps: on acceptance the key is compared in every cell at once and the cell flags
// are registered; then the flags are decoded, the cells shift and the result register
// loads. The next item is taken only once the result is loaded and is not held by
// rsp_stall, so the block works on one item at a time.
// Reset: synchronous, active high; clears the record count and the handshake
// state. Record contents are not cleared and need no clearing pass.
`include "sorted_key_record_table_core_macros.svh"

module sorted_key_record_table_core #(
  parameter int CAPACITY = skrt_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  skrt_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output skrt_pkg::rsp_t rsp
);
  import skrt_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic               busy;
  logic [CNT_W-1:0]   fill;
  cmd_t               op_cmd;
  logic signed [31:0] op_key;
  logic [63:0]        op_name;
  logic               accept;
  ctl_t               ctl;

  logic signed [31:0] cell_key  [CAPACITY];
  logic [63:0]        cell_name [CAPACITY];
  logic [CAPACITY-1:0] cell_lt;
  logic [CAPACITY-1:0] cell_eq;
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] left_lt;
  logic [CAPACITY-1:0] bnd;

  logic             hit;
  logic             full;
  logic [IDX_W-1:0] pos_acc;
  logic [63:0]      name_acc;
  logic             do_ins;
  logic             do_del;
  rsp_t             rsp_next;

  // request handshake
  assign req_stall = busy || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;

  // chain of cells
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic signed [31:0] lk;
    logic [63:0]        ln;
    logic signed [31:0] rk;
    logic [63:0]        rn;

    assign occ[j] = (CNT_W'(j) < fill);

    if (j == 0) begin : g_first
      assign left_lt[j] = 1'b1;
      assign lk = '0;
      assign ln = '0;
    end else begin : g_mid
      assign left_lt[j] = cell_lt[j-1];
      assign lk = cell_key[j-1];
      assign ln = cell_name[j-1];
    end

    if (j == CAPACITY - 1) begin : g_last
      assign rk = '0;
      assign rn = '0;
    end else begin : g_inner
      assign rk = cell_key[j+1];
      assign rn = cell_name[j+1];
    end

    assign bnd[j] = !cell_lt[j] && left_lt[j];

    skrt_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (occ[j]),
      .left_lt    (left_lt[j]),
      .left_key   (lk),
      .left_name  (ln),
      .right_key  (rk),
      .right_name (rn),
      .key        (cell_key[j]),
      .name       (cell_name[j]),
      .lt         (cell_lt[j]),
      .eq         (cell_eq[j])
    );
  end

  // gather position and name from the flagged cells
  always_comb begin
    pos_acc  = '0;
    name_acc = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      if (bnd[j]) pos_acc = pos_acc | IDX_W'(j);
      if (cell_eq[j]) name_acc = name_acc | cell_name[j];
    end
  end

  assign hit  = |cell_eq;
  assign full = (fill == CNT_W'(CAPACITY));

  // decode the operation
  always_comb begin
    do_ins   = 1'b0;
    do_del   = 1'b0;
    rsp_next = '0;
    case (op_cmd)
      CMD_INSERT: begin
        if (hit) begin
          rsp_next.status   = ST_DUPLICATE;
          rsp_next.position = 4'(pos_acc);
        end else if (full) begin
          rsp_next.status = ST_FULL;
        end else begin
          do_ins            = 1'b1;
          rsp_next.status   = ST_INSERTED;
          rsp_next.position = 4'(pos_acc);
        end
      end
      CMD_DELETE: begin
        if (hit) begin
          do_del            = 1'b1;
          rsp_next.status   = ST_DELETED;
          rsp_next.name_out = name_acc;
          rsp_next.position = 4'(pos_acc);
        end else begin
          rsp_next.status = ST_NOT_FOUND;
        end
      end
      default: begin
        if (hit) begin
          rsp_next.status   = ST_FOUND;
          rsp_next.name_out = name_acc;
          rsp_next.position = 4'(pos_acc);
        end else begin
          rsp_next.status = ST_NOT_FOUND;
        end
      end
    endcase
    if (do_ins) rsp_next.entry_count = 5'(fill + CNT_W'(1));
    else if (do_del) rsp_next.entry_count = 5'(fill - CNT_W'(1));
    else rsp_next.entry_count = 5'(fill);
  end

  // cell control
  always_comb begin
    ctl.cmp      = accept;
    ctl.ins      = busy && do_ins;
    ctl.del      = busy && do_del;
    ctl.cmp_key  = req.key;
    ctl.new_key  = op_key;
    ctl.new_name = op_name;
  end

  // held request fields
  always_ff @(posedge clk) begin
    if (accept) begin
      op_cmd  <= req.cmd;
      op_key  <= req.key;
      op_name <= req.name_tag;
    end
  end

  // control state, record count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      fill      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      if (accept) begin
        busy <= 1'b1;
      end else if (busy) begin
        busy      <= 1'b0;
        rsp_valid <= 1'b1;
        if (do_ins) fill <= fill + CNT_W'(1);
        else if (do_del) fill <= fill - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      rsp <= rsp_next;
    end
  end

  // checks
  `SKRT_CHECK_ALWAYS(a_reset_clear, rst |=> (fill == '0 && !busy && !rsp_valid), "reset did not clear state")
  `SKRT_CHECK(a_fill_bound, fill <= CNT_W'(CAPACITY), "record count above capacity")
  `SKRT_CHECK(a_key_unique, busy |-> $onehot0(cell_eq), "key matched in more than one cell")
  `SKRT_CHECK(a_accept_busy, accept |=> busy, "accepted item did not start")
  `SKRT_CHECK(a_rsp_after_busy, $rose(rsp_valid) |-> $past(busy), "result without a pending item")
  `SKRT_CHECK(a_no_accept_busy, busy |-> !accept, "item accepted while one is pending")

endmodule

FILE: rtl/skrt_cell.sv
`timescale 1ns / 1ps

module skrt_cell (
  input  logic               clk,
  input  skrt_pkg::ctl_t     ctl,
  input  logic               occupied,
  input  logic               left_lt,
  input  logic signed [31:0] left_key,
  input  logic [63:0]        left_name,
  input  logic signed [31:0] right_key,
  input  logic [63:0]        right_name,
  output logic signed [31:0] key,
  output logic [63:0]        name,
  output logic               lt,
  output logic               eq
);
  import skrt_pkg::*;

  // compare against the incoming key, then shift or load on commit
  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      lt <= occupied && (key < ctl.cmp_key);
      eq <= occupied && (key == ctl.cmp_key);
    end
    if (ctl.ins && !lt) begin
      // first cell not below the key takes the new record, the rest move right
      if (left_lt) begin
        key  <= ctl.new_key;
        name <= ctl.new_name;
      end else begin
        key  <= left_key;
        name <= left_name;
      end
    end else if (ctl.del && !lt) begin
      // records at and after the hit move left
      key  <= right_key;
      name <= right_name;
    end
  end

endmodule

FILE: tb/sv/sorted_key_record_table_core_tb.sv
`timescale 1ns / 1ps

module sorted_key_record_table_core_tb;
  import skrt_pkg::*;

  localparam int CAP          = CAPACITY_DEF;
  localparam int LIMIT_CYCLES = 600000;
  localparam int RANDOM_ITEMS = 1500;
  localparam int POOL_SIZE    = 20;
  localparam int HOLD_CYCLES  = 300;
  // unused operation code, the block treats it as a search
  localparam cmd_t CMD_SPARE  = 2'd3;

  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam logic [63:0] NAME_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NAME_MIX  = 64'h0123_4567_89AB_CDEF;

  // one row of the directed table
  typedef struct packed {
    req_t       rq;
    logic [4:0] rep;
    logic       fixed;
    rsp_t       exp;
  } step_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // typed expectation carried next to the item on offer
  logic offer_fixed = 1'b0;
  rsp_t offer_exp = '0;

  // shadow copy of the sorted table
  logic signed [31:0] shadow_keys [CAP];
  logic [63:0]        shadow_names [CAP];
  int                 shadow_fill = 0;

  rsp_t      pending_rsp_q[$];
  step_row_t plan_q[$];
  int        err_count = 0;
  int        cycle_count = 0;
  bit        gaps_off = 1'b0;
  bit        long_hold_due = 1'b0;
  bit        receiver_holding = 1'b0;

  sorted_key_record_table_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // apply one operation to the shadow table and return its result item
  function automatic rsp_t table_apply(req_t r);
    rsp_t o;
    int   idx;
    bit   hit;
    o = '0;
    idx = 0;
    while (idx < shadow_fill && $signed(shadow_keys[idx]) < $signed(r.key))
      idx++;
    hit = (idx < shadow_fill) && (shadow_keys[idx] == r.key);
    case (r.cmd)
      CMD_INSERT: begin
        if (hit) begin
          o.status   = ST_DUPLICATE;
          o.position = 4'(idx);
        end else if (shadow_fill >= CAP) begin
          o.status = ST_FULL;
        end else begin
          for (int j = shadow_fill; j > idx; j--) begin
            shadow_keys[j]  = shadow_keys[j-1];
            shadow_names[j] = shadow_names[j-1];
          end
          shadow_keys[idx]  = r.key;
          shadow_names[idx] = r.name_tag;
          shadow_fill++;
          o.status   = ST_INSERTED;
          o.position = 4'(idx);
        end
      end
      CMD_DELETE: begin
        if (hit) begin
          o.status   = ST_DELETED;
          o.name_out = shadow_names[idx];
          o.position = 4'(idx);
          for (int j = idx; j < shadow_fill - 1; j++) begin
            shadow_keys[j]  = shadow_keys[j+1];
            shadow_names[j] = shadow_names[j+1];
          end
          shadow_fill--;
        end else begin
          o.status = ST_NOT_FOUND;
        end
      end
      default: begin
        if (hit) begin
          o.status   = ST_FOUND;
          o.name_out = shadow_names[idx];
          o.position = 4'(idx);
        end else begin
          o.status = ST_NOT_FOUND;
        end
      end
    endcase
    o.entry_count = 5'(shadow_fill);
    return o;
  endfunction

  // sender gap: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic add_row(cmd_t c, logic signed [31:0] k, logic [63:0] nm, int rep,
                         bit fx, status_t st, logic [63:0] nout, int pos, int cnt);
    step_row_t row;
    row.rq.cmd            = c;
    row.rq.key            = k;
    row.rq.name_tag       = nm;
    row.rep               = 5'(rep);
    row.fixed             = fx;
    row.exp.status        = st;
    row.exp.name_out      = nout;
    row.exp.position      = 4'(pos);
    row.exp.entry_count   = 5'(cnt);
    plan_q.push_back(row);
  endtask

  // present one item, hold it until taken, then possibly idle for a random gap
  task automatic offer_item(req_t r, bit fx, rsp_t ex);
    int gap;
    req         <= r;
    req_valid   <= 1'b1;
    offer_fixed <= fx;
    offer_exp   <= ex;
    do @(posedge clk); while (req_stall);
    gap = (gaps_off || receiver_holding) ? 0 : pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait until every result item has come back
  task automatic drain_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp_q.size() != 0) @(posedge clk);
  endtask

  // predict on accepted requests, check accepted results
  always @(posedge clk) begin : monitor
    rsp_t want;
    rsp_t pred;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (pending_rsp_q.size() == 0) begin
          $display("%0t: result item with nothing expected, got status %0d",
                   $time, rsp.status);
          err_count++;
        end else begin
          want = pending_rsp_q.pop_front();
          if (rsp.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, rsp.status);
            err_count++;
          end
          if (rsp.name_out !== want.name_out) begin
            $display("%0t: name_out expected %h actual %h", $time, want.name_out,
                     rsp.name_out);
            err_count++;
          end
          if (rsp.position !== want.position) begin
            $display("%0t: position expected %0d actual %0d", $time, want.position,
                     rsp.position);
            err_count++;
          end
          if (rsp.entry_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time,
                     want.entry_count, rsp.entry_count);
            err_count++;
          end
        end
      end
      if (req_valid && !req_stall) begin
        pred = table_apply(req);
        pending_rsp_q.push_back(offer_fixed ? offer_exp : pred);
      end
    end
  end

  // result side: random stall pattern plus one long hold-off on request
  initial begin : receiver
    int free_len;
    int stall_len;
    int r;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_due) begin
        long_hold_due    = 1'b0;
        receiver_holding = 1'b1;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        receiver_holding = 1'b0;
      end
      free_len = ($urandom_range(9) == 0) ? $urandom_range(50, 150)
                                          : $urandom_range(1, 20);
      rsp_stall <= 1'b0;
      repeat (free_len) @(posedge clk);
      r = $urandom_range(99);
      if (r < 70) stall_len = $urandom_range(1, 2);
      else if (r < 95) stall_len = $urandom_range(3, 10);
      else stall_len = $urandom_range(20, 60);
      rsp_stall <= 1'b1;
      repeat (stall_len) @(posedge clk);
    end
  end

  // run limit
  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    logic signed [31:0] key_pool [POOL_SIZE];
    step_row_t          row;
    req_t               item;
    int                 ins_weight;
    int                 r;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty table, both extremes, duplicates, full table, spare code
    add_row(CMD_SEARCH, 0, 0, 1, 1, ST_NOT_FOUND, 0, 0, 0);
    add_row(CMD_DELETE, KEY_MIN, NAME_ONES, 1, 1, ST_NOT_FOUND, 0, 0, 0);
    add_row(CMD_SPARE, 7, 0, 1, 1, ST_NOT_FOUND, 0, 0, 0);
    add_row(CMD_INSERT, KEY_MIN, NAME_ONES, 1, 1, ST_INSERTED, 0, 0, 1);
    add_row(CMD_INSERT, KEY_MAX, 0, 1, 1, ST_INSERTED, 0, 1, 2);
    add_row(CMD_INSERT, 0, NAME_MIX, 1, 1, ST_INSERTED, 0, 1, 3);
    add_row(CMD_INSERT, KEY_MAX, 64'd5, 1, 1, ST_DUPLICATE, 0, 2, 3);
    add_row(CMD_SEARCH, -1, 0, 1, 1, ST_NOT_FOUND, 0, 0, 3);
    add_row(CMD_SEARCH, KEY_MIN, 0, 1, 1, ST_FOUND, NAME_ONES, 0, 3);
    add_row(CMD_SPARE, 0, 0, 1, 1, ST_FOUND, NAME_MIX, 1, 3);
    add_row(CMD_DELETE, 0, 0, 1, 1, ST_DELETED, NAME_MIX, 1, 2);
    add_row(CMD_DELETE, 0, 0, 1, 1, ST_NOT_FOUND, 0, 0, 2);
    // keys 100..113 fill the table to capacity
    add_row(CMD_INSERT, 100, 0, CAP - 2, 0, ST_INSERTED, 0, 0, 0);
    add_row(CMD_INSERT, 50, NAME_MIX, 1, 1, ST_FULL, 0, 0, CAP);
    add_row(CMD_INSERT, 107, NAME_MIX, 1, 1, ST_DUPLICATE, 0, 8, CAP);
    add_row(CMD_SEARCH, KEY_MAX, 0, 1, 1, ST_FOUND, 0, CAP - 1, CAP);
    add_row(CMD_DELETE, KEY_MAX, 0, 1, 1, ST_DELETED, 0, CAP - 1, CAP - 1);
    add_row(CMD_DELETE, KEY_MIN, 0, 1, 1, ST_DELETED, NAME_ONES, 0, CAP - 2);
    add_row(CMD_INSERT, -5, NAME_ONES, 1, 1, ST_INSERTED, 0, 0, CAP - 1);
    add_row(CMD_SEARCH, 113, 0, 1, 0, ST_FOUND, 0, 0, 0);
    add_row(CMD_DELETE, 106, 0, 1, 0, ST_DELETED, 0, 0, 0);

    foreach (plan_q[i]) begin
      row  = plan_q[i];
      item = row.rq;
      for (int n = 0; n < row.rep; n++) begin
        if (row.rep > 1) item.name_tag = {~item.key, item.key};
        offer_item(item, row.fixed, row.exp);
        item.key = item.key + 1;
      end
    end

    // small key pool so that hits, duplicates and a full table are common
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = 0;
    key_pool[3] = -1;
    key_pool[4] = 1;
    for (int i = 5; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    ins_weight = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // new phase: shift the insert bias, sometimes run without sender gaps
      if (n % 150 == 0) begin
        case ($urandom_range(2))
          0: ins_weight = 80;
          1: ins_weight = 50;
          default: ins_weight = 20;
        endcase
        gaps_off = ($urandom_range(3) == 0);
      end
      if ($urandom_range(24) == 0)
        key_pool[$urandom_range(5, POOL_SIZE - 1)] = $urandom;

      if (n == 500) drain_results();
      if (n == 900) long_hold_due = 1'b1;

      r = $urandom_range(99);
      if (r < ins_weight) item.cmd = CMD_INSERT;
      else if (r < 97 - (100 - ins_weight) / 2) item.cmd = CMD_DELETE;
      else if (r < 97) item.cmd = CMD_SEARCH;
      else item.cmd = CMD_SPARE;
      item.key      = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                                : $urandom;
      item.name_tag = {$urandom, $urandom};
      offer_item(item, 1'b0, '0);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/skrt_pkg.sv
rtl/skrt_cell.sv
rtl/sorted_key_record_table_core.sv
tb/sv/sorted_key_record_table_core_tb.sv
